/* design/slfr_pkg.sv */
// shared types and constants for the sync length frame receiver
package slfr_pkg;

	localparam int BUF_DEPTH_DEF = 64;
	localparam int HEADER_SLACK = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] SYNC_FIRST = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_REARM = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_REJECTED = 2'd2
	} status_t;

	typedef struct packed {
		op_t op;
		logic [7:0] data;
	} item_t;

endpackage

/* design/slfr_front.sv */
// front end: accepts input transactions, drops bad bytes and tags the rest
module slfr_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic [7:0]       rx_byte,
	input  logic             frame_error,
	input  logic             q_full,
	output logic             push,
	output slfr_pkg::item_t  push_item
);
	import slfr_pkg::*;

	logic accept;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	always_comb begin
		push_item.data = rx_byte;
		if (kind) begin
			push_item.op = OP_REARM;
		end else begin
			push_item.op = OP_BYTE;
		end
	end

	// a byte with a framing error never reaches the parser
	assign push = accept && (kind || !frame_error);

endmodule

/* design/slfr_queue.sv */
// short queue between the front end and the frame parser
module slfr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  slfr_pkg::item_t  push_item,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output slfr_pkg::item_t  head
);
	import slfr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* design/slfr_back.sv */
// frame parser: position tracking, length check and the output register
module slfr_back #(
	parameter int BUF_DEPTH = slfr_pkg::BUF_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  slfr_pkg::item_t     head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [5:0]          position,
	output logic [7:0]          value,
	output slfr_pkg::status_t   status,
	output logic [6:0]          frame_bytes
);
	import slfr_pkg::*;

	localparam int PW = $clog2(BUF_DEPTH) + 1;
	localparam logic [8:0] MAX_LEN = 9'(BUF_DEPTH - HEADER_SLACK);

	logic [PW-1:0] pos_q;
	logic [PW-1:0] end_q;
	logic          dis_q;

	logic [PW-1:0] pos_d;
	logic [PW-1:0] end_d;
	logic          dis_d;
	logic          emit;
	status_t       r_st;
	logic [6:0]    r_tot;

	logic [8:0]    len9;
	logic [8:0]    end_sum9;
	logic [8:0]    pos9;
	logic [8:0]    tot9;

	logic          out_valid_q;
	logic [5:0]    position_q;
	logic [7:0]    value_q;
	status_t       status_q;
	logic [6:0]    frame_bytes_q;

	assign pop = q_not_empty && (!out_valid_q || out_ready);

	assign len9 = {1'b0, head.data};
	assign end_sum9 = len9 + 9'd4;
	assign pos9 = 9'(pos_q);
	assign tot9 = 9'(end_q) + 9'd1;

	always_comb begin
		pos_d = pos_q;
		end_d = end_q;
		dis_d = dis_q;
		emit = 1'b0;
		r_st = ST_STORED;
		r_tot = '0;
		if (head.op == OP_REARM) begin
			dis_d = 1'b0;
		end else if (!dis_q) begin
			if (pos_q == PW'(0)) begin
				if (head.data == SYNC_FIRST) begin
					pos_d = PW'(1);
				end
			end else if (pos_q == PW'(1)) begin
				pos_d = (head.data == SYNC_SECOND) ? PW'(2) : PW'(0);
			end else if (pos_q == PW'(2)) begin
				pos_d = PW'(3);
				emit = 1'b1;
			end else if (pos_q == PW'(3)) begin
				emit = 1'b1;
				if (len9 > MAX_LEN) begin
					pos_d = PW'(0);
					r_st = ST_REJECTED;
				end else begin
					pos_d = PW'(4);
					end_d = end_sum9[PW-1:0];
				end
			end else if (pos_q >= end_q) begin
				// checksum byte closes the frame
				pos_d = PW'(0);
				dis_d = 1'b1;
				emit = 1'b1;
				r_st = ST_COMPLETE;
				r_tot = tot9[6:0];
			end else begin
				pos_d = pos_q + PW'(1);
				emit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			end_q <= '0;
			dis_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_q <= pos_d;
				end_q <= end_d;
				dis_q <= dis_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			position_q <= pos9[5:0];
			value_q <= head.data;
			status_q <= r_st;
			frame_bytes_q <= r_tot;
		end
	end

	assign out_valid = out_valid_q;
	assign position = position_q;
	assign value = value_q;
	assign status = status_q;
	assign frame_bytes = frame_bytes_q;

endmodule

/* design/sync_length_frame_receiver.sv */
// top level of the sync length frame receiver
// Takes one received byte or rearm transaction per clock while the queue is not full. A
// two-entry queue sits between the input check and the frame parser, and the parser's result
// sits in an output register, so input keeps flowing while a result waits; the parser retires one
// queued transaction per cycle whenever its output register is empty or being taken, giving a
// sustained rate of one item per cycle. Frames are 0x55 0xAA, command, length, length data
// bytes, checksum; bytes from position 2 on are reported.
module sync_length_frame_receiver #(
	parameter int BUF_DEPTH = slfr_pkg::BUF_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	input  logic        frame_error,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  position,
	output logic [7:0]  value,
	output logic [1:0]  status,
	output logic [6:0]  frame_bytes
);
	import slfr_pkg::*;

	logic    q_full;
	logic    q_not_empty;
	logic    push;
	logic    pop;
	item_t   push_item;
	item_t   head;
	status_t status_e;

	slfr_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.rx_byte     (rx_byte),
		.frame_error (frame_error),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	slfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	slfr_back #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.position    (position),
		.value       (value),
		.status      (status_e),
		.frame_bytes (frame_bytes)
	);

	assign status = status_e;

	// a rejected length is always reported at the length position
	a_reject_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_REJECTED) |-> position == 6'd3)
		else $error("rejected length reported away from position 3");

	// the closing byte sits one below the frame byte count
	a_complete_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_COMPLETE) |-> (position + 6'd1) == frame_bytes[5:0])
		else $error("frame byte count does not match closing position");

	// a framing-error byte never enters the queue
	a_fe_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !kind && frame_error |-> !push)
		else $error("framing-error byte queued");

	// the queue is never pushed while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("queue overflow");

endmodule
